>>> design/wrs_pkg.sv
// shared types and constants for the weighted random selector
package wrs_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int KIND_BITS   = 2;
  localparam int WIN_BITS    = 16;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int INDEX_BITS  = 6;
  localparam int STATUS_BITS = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

>>> design/weighted_random_selector.sv
// weighted random selector: entry table, running total and draw sequencer
// load, clear, unused kind and a draw with no weight: result on the cycle after the transfer
// draw: one table read per cycle, compared from the registered read data; result on the cycle
// after the picked entry's compare
// busy holds off the next transfer until the result cycle; the single read port sets the rate
// reset clears the entry count, live total and sequencer; the receiver cannot stall
module weighted_random_selector #(
  parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [wrs_pkg::KIND_BITS-1:0]    kind_i,
  input  logic [wrs_pkg::WIN_BITS-1:0]     weight_i,
  input  logic [wrs_pkg::VALUE_BITS-1:0]   element_value_i,
  input  logic [wrs_pkg::FRAC_BITS-1:0]    random_fraction_i,
  input  logic                             remove_after_i,
  output logic                             done_o,
  output logic [wrs_pkg::VALUE_BITS-1:0]   picked_value_o,
  output logic [wrs_pkg::INDEX_BITS-1:0]   picked_index_o,
  output logic [wrs_pkg::STATUS_BITS-1:0]  status_o
);

  localparam int IW      = $clog2(MAX_ENTRIES);
  localparam int CW      = $clog2(MAX_ENTRIES + 1);
  localparam int TW      = WEIGHT_BITS + CW;
  localparam int PW      = TW + wrs_pkg::FRAC_BITS;
  localparam int VB      = wrs_pkg::VALUE_BITS;
  localparam int ENTRY_W = 1 + WEIGHT_BITS + VB;

  wrs_pkg::state_e state_q, state_d;

  logic [CW-1:0]      count_q, count_d;
  logic [TW-1:0]      total_q, total_d;
  logic [PW-1:0]      target_q, target_d;
  logic [TW-1:0]      run_q, run_d;
  logic [CW-1:0]      rd_addr_q, rd_addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               remove_q, remove_d;
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_en;

  logic                              done_q, done_d;
  logic [VB-1:0]                     value_q, value_d;
  logic [wrs_pkg::INDEX_BITS-1:0]    index_q, index_d;
  logic [wrs_pkg::STATUS_BITS-1:0]   status_q, status_d;

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [WEIGHT_BITS-1:0]          w_in;
  logic [wrs_pkg::INDEX_BITS-1:0]  load_idx;
  logic [wrs_pkg::INDEX_BITS-1:0]  hit_idx;
  logic                            rd_live;
  logic [WEIGHT_BITS-1:0]          rd_weight;
  logic [VB-1:0]                   rd_value;
  logic [TW-1:0]                   run_next;
  logic                            hit;
  logic                            last;
  logic                            full;

  assign rd_live   = rd_data_q[ENTRY_W-1];
  assign rd_weight = rd_data_q[VB +: WEIGHT_BITS];
  assign rd_value  = rd_data_q[VB-1:0];
  assign run_next  = run_q + TW'(rd_weight);
  assign hit       = rd_vld_q && rd_live &&
                     ({run_next, {wrs_pkg::FRAC_BITS{1'b0}}} > target_q);
  assign last      = (CW'(rd_idx_q) + CW'(1)) == count_q;
  assign full      = count_q == CW'(MAX_ENTRIES);

  // weight masked or zero-extended to the stored width, indexes cut to the port
  always_comb begin
    w_in     = '0;
    load_idx = '0;
    hit_idx  = '0;
    for (int b = 0; b < WEIGHT_BITS && b < wrs_pkg::WIN_BITS; b++) begin
      w_in[b] = weight_i[b];
    end
    for (int b = 0; b < IW && b < wrs_pkg::INDEX_BITS; b++) begin
      load_idx[b] = count_q[b];
      hit_idx[b]  = rd_idx_q[b];
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    total_d   = total_q;
    target_d  = target_q;
    run_d     = run_q;
    rd_addr_d = rd_addr_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    remove_d  = remove_q;
    rd_en     = 1'b0;
    done_d    = 1'b0;
    value_d   = value_q;
    index_d   = index_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;

    case (state_q)
      wrs_pkg::ST_IDLE: begin
        if (start) begin
          value_d  = '0;
          index_d  = '0;
          status_d = wrs_pkg::STATUS_OK;
          case (wrs_pkg::kind_e'(kind_i))
            wrs_pkg::KIND_LOAD: begin
              done_d = 1'b1;
              if (full) begin
                status_d = wrs_pkg::STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IW-1:0];
                mem_wdata = {1'b1, w_in, element_value_i};
                count_d   = count_q + CW'(1);
                total_d   = total_q + TW'(w_in);
                index_d   = load_idx;
              end
            end
            wrs_pkg::KIND_DRAW: begin
              remove_d = remove_after_i;
              if (total_q == '0) begin
                done_d   = 1'b1;
                status_d = wrs_pkg::STATUS_EMPTY;
              end else begin
                state_d   = wrs_pkg::ST_SCAN;
                target_d  = PW'(random_fraction_i) * PW'(total_q);
                run_d     = '0;
                rd_addr_d = '0;
              end
            end
            wrs_pkg::KIND_CLEAR: begin
              done_d  = 1'b1;
              count_d = '0;
              total_d = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      wrs_pkg::ST_SCAN: begin
        if (rd_addr_q < count_q) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = rd_addr_q[IW-1:0];
          rd_addr_d = rd_addr_q + CW'(1);
        end
        if (rd_vld_q && rd_live) begin
          run_d = run_next;
        end
        if (hit) begin
          state_d  = wrs_pkg::ST_IDLE;
          rd_vld_d = 1'b0;
          done_d   = 1'b1;
          value_d  = rd_value;
          index_d  = hit_idx;
          status_d = wrs_pkg::STATUS_OK;
          if (remove_q) begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_q;
            mem_wdata = {1'b0, rd_weight, rd_value};
            total_d   = total_q - TW'(rd_weight);
          end
        end else if (rd_vld_q && last) begin
          // live total and table disagree: report no weight
          state_d  = wrs_pkg::ST_IDLE;
          rd_vld_d = 1'b0;
          done_d   = 1'b1;
          value_d  = '0;
          index_d  = '0;
          status_d = wrs_pkg::STATUS_EMPTY;
        end
      end
      default: begin
        state_d = wrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wrs_pkg::ST_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    run_q     <= run_d;
    rd_addr_q <= rd_addr_d;
    rd_idx_q  <= rd_idx_d;
    remove_q  <= remove_d;
    value_q   <= value_d;
    index_q   <= index_d;
    status_q  <= status_d;
  end

  // entry memory: live mark, weight, value; only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr_q[IW-1:0]];
    end
  end

  assign busy           = state_q == wrs_pkg::ST_SCAN;
  assign done_o         = done_q;
  assign picked_value_o = value_q;
  assign picked_index_o = index_q;
  assign status_o       = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_scan_has_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wrs_pkg::ST_SCAN |-> total_q != '0)
    else $error("draw scan running with no live weight");

  a_idle_transfer_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i != wrs_pkg::KIND_DRAW |=> done_o && !busy)
    else $error("non-draw transfer gave no result on the next cycle");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == wrs_pkg::ST_SCAN))
    else $error("table read outside a draw scan");

  a_done_leaves_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wrs_pkg::ST_SCAN && state_d == wrs_pkg::ST_IDLE |=> done_o)
    else $error("draw ended without a result");

endmodule
